// ===== rtl/rfi_pkg.sv =====
// rfi_pkg: shared types and constants for the ray/facet intersect block.
// No dependencies.
`default_nettype none
package rfi_pkg;
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_PLANE = 2'd2;
  localparam logic [1:0] MODE_EDGE  = 2'd3;
  localparam logic [16:0] NO_HIT    = 17'h10000;
  localparam int MIN_EDGES          = 3;
  // coordinates are Q23.8 throughout; the datapath never rescales them
  localparam int COORD_FRAC_BITS    = 8;

  // configuration register indexes
  localparam logic REG_EDGE_EPS     = 1'b0;
  localparam logic REG_SELF_MARGIN  = 1'b1;

  // queued word from front to back
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] vw;
    logic [2:0]         edge_count;
    logic               see_through;
  } word_t;
endpackage
`default_nettype wire

// ===== rtl/rfi_queue.sv =====
// rfi_queue: two-entry word queue between front and back.
// Depends on rfi_pkg.
`default_nettype none
module rfi_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rfi_pkg::word_t in_word,
  output logic                out_valid,
  input  wire logic           out_take,
  output rfi_pkg::word_t      out_word
);
  import rfi_pkg::*;
  word_t mem [2];
  logic rd, wr;
  logic [1:0] cnt;
  assign in_stall  = cnt == 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_word  = mem[rd];
  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0; wr <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && !in_stall) begin
        mem[wr] <= in_word;
        wr <= !wr;
      end
      if (out_take && out_valid) rd <= !rd;
      cnt <= cnt + 2'(in_valid && !in_stall) - 2'(out_take && out_valid);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rfi_back.sv =====
// rfi_back: sequencer that evaluates plane/edge words, divides, forms the point.
// Depends on rfi_pkg.
`default_nettype none
module rfi_back #(
  parameter int NORMAL_FRAC_BITS = 14,
  parameter int MAX_EDGES        = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [7:0]     edge_epsilon,
  input  wire logic [15:0]    self_margin,
  input  wire logic           q_valid,
  output logic                q_take,
  input  wire rfi_pkg::word_t q_word,
  output logic                res_valid,
  input  wire logic           res_stall,
  output logic                facet_hit,
  output logic                closer_hit,
  output logic [16:0]         hit_fraction,
  output logic signed [31:0]  point_x,
  output logic signed [31:0]  point_y,
  output logic signed [31:0]  point_z
);
  import rfi_pkg::*;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_SUM = 4'd2, S_D1 = 4'd3,
    S_D2 = 4'd4, S_DIV = 4'd5, S_PT = 4'd6, S_PTS = 4'd7, S_EDGE = 4'd8, S_OUT = 4'd9;

  logic [3:0] state;
  logic signed [31:0] rs [3];
  logic signed [31:0] re [3];
  logic [16:0] best, cand_f;
  logic signed [31:0] cand_p [3];
  logic live, outside, see;
  logic [EW-1:0] left;
  word_t w;
  logic which;               // 0: start point, 1: end point
  logic [1:0] lane;          // product lane counter
  logic signed [63:0] prod;
  logic signed [65:0] acc, d1;
  logic [65:0] an, ad, rem;
  logic [15:0] q;
  logic [4:0] step;
  logic o_hit;
  logic signed [31:0] pa, pb;
  logic signed [33:0] diff;
  logic signed [50:0] pprod;

  // one multiplier shared over the three lanes
  always_comb begin
    unique case (lane)
      2'd0: begin pa = (state==S_EDGE) ? cand_p[0] : (which ? re[0] : rs[0]); pb = w.vx; end
      2'd1: begin pa = (state==S_EDGE) ? cand_p[1] : (which ? re[1] : rs[1]); pb = w.vy; end
      default: begin pa = (state==S_EDGE) ? cand_p[2] : (which ? re[2] : rs[2]); pb = w.vz; end
    endcase
    diff = 34'(re[lane]) - 34'(rs[lane]);
    pprod = 51'(diff) * 51'(signed'({1'b0, q}));
  end

  logic signed [65:0] margin_s, eps_s, den, num;
  logic [65:0] rem2;
  logic [EW-1:0] cnt_sat;
  always_comb begin
    margin_s = 66'(self_margin);
    eps_s = 66'(edge_epsilon);
    den = d1 - acc;
    num = d1 - eps_s;
    an = num[65] ? 66'(-num) : 66'(num);
    rem2 = {rem[64:0], 1'b0};
    cnt_sat = (int'(q_word.edge_count) > MAX_EDGES) ? EW'(MAX_EDGES)
                                                    : EW'(q_word.edge_count);
  end

  assign q_take = (state == S_IDLE) && !(res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; live <= 1'b0; outside <= 1'b0; see <= 1'b0; left <= '0;
      best <= NO_HIT; cand_f <= '0; res_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin rs[i] <= '0; re[i] <= '0; cand_p[i] <= '0; end
    end else begin
      if (state == S_OUT && (!res_valid || !res_stall)) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid && q_take) begin
          w <= q_word;
          unique case (q_word.mode)
            MODE_START: begin
              rs[0] <= q_word.vx; rs[1] <= q_word.vy; rs[2] <= q_word.vz;
              best <= NO_HIT; live <= 1'b0; left <= '0;
            end
            MODE_END: begin
              re[0] <= q_word.vx; re[1] <= q_word.vy; re[2] <= q_word.vz;
              live <= 1'b0; left <= '0;
            end
            MODE_PLANE: begin
              see <= q_word.see_through; outside <= 1'b1; left <= cnt_sat;
              live <= cnt_sat != '0;
              if (cnt_sat == '0) begin
                o_hit <= 1'b0; state <= S_OUT;
              end else if (cnt_sat >= EW'(MIN_EDGES)) begin
                which <= 1'b0; lane <= 2'd0; acc <= '0; state <= S_MUL;
              end
            end
            default: if (live) begin
              if (outside) begin
                state <= S_SUM; lane <= 2'd3;   // skip straight to bookkeeping
              end else begin
                lane <= 2'd0; acc <= '0; state <= S_EDGE;
              end
            end
          endcase
        end
        S_MUL, S_EDGE: begin
          prod <= 64'(pa) * 64'(pb);
          state <= S_SUM;
        end
        S_SUM: begin
          if (lane != 2'd3) begin
            acc <= acc + 66'(prod >>> NORMAL_FRAC_BITS);
          end
          if (lane == 2'd2 || lane == 2'd3) begin
            if (w.mode == MODE_EDGE) state <= S_D2;   // edge finish
            else state <= which ? S_D2 : S_D1;
          end else begin
            lane <= lane + 2'd1;
            state <= (w.mode == MODE_EDGE) ? S_EDGE : S_MUL;
          end
        end
        S_D1: begin
          d1 <= acc - 66'(w.vw);
          if ((acc - 66'(w.vw)) > -margin_s && (acc - 66'(w.vw)) < margin_s) begin
            state <= S_IDLE;
          end else begin
            which <= 1'b1; lane <= 2'd0; acc <= '0; state <= S_MUL;
          end
        end
        S_D2: begin
          if (w.mode == MODE_EDGE) begin
            if (lane != 2'd3 && !outside &&
                acc > 66'(w.vw) + eps_s) outside <= 1'b1;
            left <= left - EW'(1);
            if (left == EW'(1)) begin
              live <= 1'b0;
              o_hit <= !(outside || (lane != 2'd3 &&
                         acc > 66'(w.vw) + eps_s));
              state <= S_OUT;
            end else state <= S_IDLE;
          end else begin
            acc <= acc - 66'(w.vw);   // acc becomes d2
            state <= S_DIV;
            step <= 5'd0;
          end
        end
        S_DIV: begin
          if (step == 5'd0) begin
            if (acc > -margin_s && acc < margin_s) state <= S_IDLE;
            else if (den == 0) state <= S_IDLE;
            else if (!((num > 0 && den > 0) || (num < 0 && den < 0))) state <= S_IDLE;
            else begin
              ad <= den[65] ? 66'(-den) : 66'(den);
              if (an >= (den[65] ? 66'(-den) : 66'(den))) state <= S_IDLE;
              else begin rem <= an; q <= '0; step <= 5'd1; end
            end
          end else begin
            if (rem2 >= ad) begin rem <= rem2 - ad; q <= {q[14:0], 1'b1}; end
            else begin rem <= rem2; q <= {q[14:0], 1'b0}; end
            if (step == 5'd16) state <= S_PT;
            step <= step + 5'd1;
          end
        end
        S_PT: begin
          if (q == '0 || 17'(q) >= best) state <= S_IDLE;
          else begin
            cand_f <= 17'(q); lane <= 2'd0; state <= S_PTS;
          end
        end
        S_PTS: begin
          cand_p[lane] <= rs[lane] + 32'(pprod >>> 16);
          if (lane == 2'd2) begin outside <= 1'b0; state <= S_IDLE; end
          lane <= lane + 2'd1;
        end
        default: begin  // S_OUT
          if (!res_valid || !res_stall) begin
            facet_hit <= o_hit && w.mode == MODE_EDGE;
            closer_hit <= o_hit && !see && w.mode == MODE_EDGE;
            if (o_hit && !see && w.mode == MODE_EDGE) begin
              best <= cand_f; hit_fraction <= cand_f;
            end else hit_fraction <= best;
            point_x <= (o_hit && w.mode == MODE_EDGE) ? cand_p[0] : '0;
            point_y <= (o_hit && w.mode == MODE_EDGE) ? cand_p[1] : '0;
            point_z <= (o_hit && w.mode == MODE_EDGE) ? cand_p[2] : '0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ray_facet_intersect.sv =====
// ray_facet_intersect: top level, front register file and queue into back sequencer.
// Depends on rfi_pkg, rfi_queue, rfi_back.
//
// Use: words arrive on in_valid/in_stall with mode selecting ray start, ray
// end, facet plane or edge plane. A facet plane is followed by its edge words.
// After the last edge word (or at once for a facet with no edges) one result
// word appears on out_valid/out_stall.
// A ray word is applied once the sequencer takes it from the queue. A facet
// plane holds the sequencer for up to two 3-lane dot products on one shared
// multiplier, a 16-step restoring divide, one quotient bit a cycle, then 3
// point multiplies; an edge word holds it for at most one 3-lane dot product.
// The result word is registered after the last edge word, or after a plane
// with no edges, once the sequencer reaches its output state.
// A two-word queue lets the input side keep accepting while the sequencer
// works or waits on a stalled result. When out_stall is high the result word
// holds and the sequencer waits before emitting the next one.
// Reset clears the ray, best fraction (no hit) and registers to defaults.
`default_nettype none
module ray_facet_intersect #(
  parameter int NORMAL_FRAC_BITS = 14,
  parameter int MAX_EDGES        = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] vx,
  input  wire logic signed [31:0] vy,
  input  wire logic signed [31:0] vz,
  input  wire logic signed [31:0] vw,
  input  wire logic [2:0]         edge_count,
  input  wire logic               see_through,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    facet_hit,
  output logic                    closer_hit,
  output logic [16:0]             hit_fraction,
  output logic signed [31:0]      point_x,
  output logic signed [31:0]      point_y,
  output logic signed [31:0]      point_z
);
  import rfi_pkg::*;

  logic [7:0]  edge_epsilon;
  logic [15:0] self_margin;
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_epsilon <= 8'd26; self_margin <= 16'd256;
    end else if (cfg_we) begin
      if (cfg_index == REG_EDGE_EPS) edge_epsilon <= cfg_data[7:0];
      else if (cfg_index == REG_SELF_MARGIN) self_margin <= cfg_data;
    end
  end

  word_t in_word, q_word;
  logic q_valid, q_take;
  always_comb begin
    in_word.mode = mode; in_word.vx = vx; in_word.vy = vy; in_word.vz = vz;
    in_word.vw = vw; in_word.edge_count = edge_count; in_word.see_through = see_through;
  end

  rfi_queue u_queue (
    .clk, .rst, .in_valid, .in_stall, .in_word,
    .out_valid(q_valid), .out_take(q_take), .out_word(q_word)
  );

  rfi_back #(
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS), .MAX_EDGES(MAX_EDGES)
  ) u_back (
    .clk, .rst, .edge_epsilon, .self_margin, .q_valid, .q_take, .q_word,
    .res_valid(out_valid), .res_stall(out_stall), .facet_hit, .closer_hit,
    .hit_fraction, .point_x, .point_y, .point_z
  );

  // a closer hit is always a hit
  a_closer: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!closer_hit || facet_hit)) else $error("closer without hit");
  // a miss reports a zero point
  a_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !facet_hit) |-> (point_x == 0 && point_y == 0 && point_z == 0))
    else $error("miss with point");
  // fraction in range
  a_frac: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit_fraction <= NO_HIT) else $error("fraction range");
endmodule
`default_nettype wire

// ===== verif/ray_facet_intersect_test.sv =====
// ray_facet_intersect_test: self-checking bench for the ray/facet intersect block.
// Depends on rfi_pkg and ray_facet_intersect; a built-in predictor checks every result word.
`timescale 1ns / 1ps
module ray_facet_intersect_test;
  import rfi_pkg::*;

  localparam int NORM_SHIFT = 14;
  localparam int EDGE_LIMIT = 4;
  localparam int DRAIN_CYCLES = 200;  // past up to three queued plane words
  localparam int WORD_TARGET = 1450;

  // one result word as the block reports it
  typedef struct packed {
    logic               hit;
    logic               closer;
    logic [16:0]        frac;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } hit_t;

  // directed stimulus row; typed rows carry a hand-read result
  typedef struct {
    word_t w;
    bit    typed;
    hit_t  r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_START;
  logic signed [31:0] vx = '0, vy = '0, vz = '0, vw = '0;
  logic [2:0] edge_count = '0;
  logic see_through = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic facet_hit, closer_hit;
  logic [16:0] hit_fraction;
  logic signed [31:0] point_x, point_y, point_z;

  ray_facet_intersect DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .vx(vx), .vy(vy), .vz(vz), .vw(vw),
    .edge_count(edge_count), .see_through(see_through),
    .out_valid(out_valid), .out_stall(out_stall),
    .facet_hit(facet_hit), .closer_hit(closer_hit), .hit_fraction(hit_fraction),
    .point_x(point_x), .point_y(point_y), .point_z(point_z)
  );

  always #1 clk = ~clk;

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: ray ends, best and candidate hit, facet in progress
  // ---------------------------------------------------------------------------
  longint ray_a[3], ray_b[3], cand_pt[3];
  logic [16:0] best_frac, cand_frac;
  bit facet_open, facet_out, facet_clear;
  int edges_due;
  longint eps_q8, margin_q8;

  hit_t pending[$];      // results still owed by the block
  int mismatches = 0;
  int words_sent = 0, words_seen = 0, hits_seen = 0, closer_seen = 0, settings_used = 1;
  bit calm = 1'b0;       // stretch with no idling on either side

  // signed plane distance: floor-shifted products summed, minus w
  function automatic longint plane_dist(longint p0, longint p1, longint p2,
                                        longint n0, longint n1, longint n2, longint w);
    return ((p0 * n0) >>> NORM_SHIFT) + ((p1 * n1) >>> NORM_SHIFT)
         + ((p2 * n2) >>> NORM_SHIFT) - w;
  endfunction

  // plane crossing test; on success leaves the candidate fraction and point
  function automatic bit crosses(longint n0, longint n1, longint n2, longint w);
    longint d1, d2, den, num, an, ad, r;
    logic [16:0] q;
    d1 = plane_dist(ray_a[0], ray_a[1], ray_a[2], n0, n1, n2, w);
    if (d1 > -margin_q8 && d1 < margin_q8) return 1'b0;
    d2 = plane_dist(ray_b[0], ray_b[1], ray_b[2], n0, n1, n2, w);
    if (d2 > -margin_q8 && d2 < margin_q8) return 1'b0;
    den = d1 - d2;
    if (den == 0) return 1'b0;
    num = d1 - eps_q8;
    if (!((num > 0 && den > 0) || (num < 0 && den < 0))) return 1'b0;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    if (an >= ad) return 1'b0;
    r = an;
    q = '0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ad) begin
        r = r - ad;
        q[0] = 1'b1;
      end
    end
    if (q == 0 || q >= best_frac) return 1'b0;
    cand_frac = q;
    for (int i = 0; i < 3; i++)
      cand_pt[i] = ray_a[i] + (((ray_b[i] - ray_a[i]) * longint'(q)) >>> 16);
    return 1'b1;
  endfunction

  function automatic hit_t report(bit hit, bit closer);
    hit_t r;
    r = '0;
    r.hit = hit;
    r.closer = closer;
    r.frac = best_frac;
    if (hit) begin
      r.px = cand_pt[0][31:0];
      r.py = cand_pt[1][31:0];
      r.pz = cand_pt[2][31:0];
    end
    return r;
  endfunction

  // advance the predictor by one accepted word
  task automatic intersect_step(input word_t w, output bit has, output hit_t r);
    longint v0, v1, v2, wv, d;
    int cnt;
    has = 1'b0;
    r = '0;
    v0 = w.vx;
    v1 = w.vy;
    v2 = w.vz;
    wv = w.vw;
    case (w.mode)
      MODE_START, MODE_END: begin
        if (w.mode == MODE_START) begin
          ray_a[0] = v0; ray_a[1] = v1; ray_a[2] = v2;
          best_frac = NO_HIT;
        end else begin
          ray_b[0] = v0; ray_b[1] = v1; ray_b[2] = v2;
        end
        facet_open = 1'b0;
        edges_due = 0;
      end
      MODE_PLANE: begin
        cnt = w.edge_count > EDGE_LIMIT ? EDGE_LIMIT : w.edge_count;
        facet_clear = w.see_through;
        facet_out = 1'b1;
        if (cnt >= MIN_EDGES) facet_out = !crosses(v0, v1, v2, wv);
        if (cnt == 0) begin
          facet_open = 1'b0;
          edges_due = 0;
          has = 1'b1;
          r = report(1'b0, 1'b0);
        end else begin
          facet_open = 1'b1;
          edges_due = cnt;
        end
      end
      default: begin
        if (facet_open) begin
          if (!facet_out) begin
            d = plane_dist(cand_pt[0], cand_pt[1], cand_pt[2], v0, v1, v2, 0);
            if (d > wv + eps_q8) facet_out = 1'b1;
          end
          edges_due--;
          if (edges_due == 0) begin
            facet_open = 1'b0;
            has = 1'b1;
            if (!facet_out && !facet_clear) begin
              best_frac = cand_frac;
              r = report(1'b1, 1'b1);
            end else begin
              r = report(!facet_out, 1'b0);
            end
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall and compare against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  int stall_hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 2) == 0);
      stall_hold <= gap_len();
    end
  end

  always @(posedge clk) begin : result_check
    hit_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{facet_hit, closer_hit, hit_fraction, point_x, point_y, point_z};
      words_seen++;
      if (got.hit) hits_seen++;
      if (got.closer) closer_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %p", got);
      end else begin
        want = pending.pop_front();
        if (got.hit !== want.hit || got.closer !== want.closer || got.frac !== want.frac
            || got.px !== want.px || got.py !== want.py || got.pz !== want.pz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %p, got %p", words_seen, want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  function automatic word_t mkw(logic [1:0] m, int x, int y, int z, int w,
                                int cnt = 0, bit st = 0);
    word_t o;
    o.mode = m; o.vx = x; o.vy = y; o.vz = z; o.vw = w;
    o.edge_count = cnt[2:0]; o.see_through = st;
    return o;
  endfunction

  // present one word after a random gap and hold it until taken
  task automatic send(input word_t w, input bit typed = 0, input hit_t typed_r = '0);
    int g;
    bit has;
    hit_t r;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= w.mode; vx <= w.vx; vy <= w.vy; vz <= w.vz; vw <= w.vw;
    edge_count <= w.edge_count; see_through <= w.see_through;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    intersect_step(w, has, r);
    if (has) pending.push_back(typed ? typed_r : r);
    words_sent++;
  endtask

  // hold off until every owed result is back and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_EDGE_EPS) eps_q8 = value[7:0];
    else margin_q8 = value;
  endtask

  function automatic int rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return int'($urandom_range(0, 2 << 20)) - (1 << 20);
  endfunction

  function automatic int rand_norm();
    if ($urandom_range(0, 15) == 0) return $urandom;
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  // a facet whose plane lies between the ray ends, edges mostly around the crossing
  task automatic send_facet(input int cnt, input int cut_after);
    int n0, n1, n2, e0, e1, e2;
    longint s1, s2, wp, d;
    n0 = rand_norm(); n1 = rand_norm(); n2 = rand_norm();
    s1 = plane_dist(ray_a[0], ray_a[1], ray_a[2], n0, n1, n2, 0);
    s2 = plane_dist(ray_b[0], ray_b[1], ray_b[2], n0, n1, n2, 0);
    wp = s1 + (s2 - s1) * longint'(int'($urandom_range(0, 1000))) / 1000;
    send(mkw(MODE_PLANE, n0, n1, n2, int'(wp), cnt, $urandom_range(0, 3) == 0));
    for (int i = 0; i < (cnt > EDGE_LIMIT ? EDGE_LIMIT : cnt); i++) begin
      if (i == cut_after) return;
      e0 = rand_norm(); e1 = rand_norm(); e2 = rand_norm();
      d = plane_dist(cand_pt[0], cand_pt[1], cand_pt[2], e0, e1, e2, 0);
      send(mkw(MODE_EDGE, e0, e1, e2, int'(d + $urandom_range(0, 4000) - 300)));
    end
  endtask

  task automatic new_ray();
    send(mkw(MODE_START, rand_coord(), rand_coord(), rand_coord(), $urandom));
    send(mkw(MODE_END, rand_coord(), rand_coord(), rand_coord(), $urandom));
  endtask

  // directed table: ray along z from 0 to 100.0, facets across it
  row_t rows[$];
  hit_t miss_none;

  task automatic add_row(input word_t w, input bit typed = 0);
    row_t r;
    r.w = w;
    r.typed = typed;
    r.r = miss_none;
    rows.push_back(r);
  endtask

  initial begin
    int cfg_eps[4], cfg_margin[4];
    int phase;
    int p;
    // reset state of the predictor
    for (int i = 0; i < 3; i++) begin
      ray_a[i] = 0; ray_b[i] = 0; cand_pt[i] = 0;
    end
    best_frac = NO_HIT; cand_frac = '0;
    facet_open = 0; facet_out = 0; facet_clear = 0; edges_due = 0;
    eps_q8 = 26; margin_q8 = 256;
    miss_none = '0;
    miss_none.frac = NO_HIT;

    add_row(mkw(MODE_PLANE, 16384, 0, 0, 0, 0), 1);        // no edges: miss at once
    add_row(mkw(MODE_EDGE, 16384, 0, 0, 0));               // stray edge, ignored
    add_row(mkw(MODE_START, 0, 0, 0, 0));
    add_row(mkw(MODE_END, 0, 0, 25600, 0));
    add_row(mkw(MODE_PLANE, 0, 0, 16384, 12800, 4));       // z = 50, opaque
    add_row(mkw(MODE_EDGE, 16384, 0, 0, 2560));
    add_row(mkw(MODE_EDGE, -16384, 0, 0, 2560));
    add_row(mkw(MODE_EDGE, 0, 16384, 0, 2560));
    add_row(mkw(MODE_EDGE, 0, -16384, 0, 2560));
    add_row(mkw(MODE_PLANE, 0, 0, 16384, 0, 7));           // start on plane, count saturates
    repeat (4) add_row(mkw(MODE_EDGE, 16384, 0, 0, 2560));
    add_row(mkw(MODE_PLANE, 0, 0, 16384, 6400, 3, 1));     // z = 25, see-through
    add_row(mkw(MODE_EDGE, 16384, 0, 0, 2560));
    add_row(mkw(MODE_EDGE, 0, 16384, 0, 2560));
    add_row(mkw(MODE_EDGE, 0, -16384, 0, 2560));
    add_row(mkw(MODE_PLANE, 0, 0, 16384, 3200, 2));        // degenerate, edges consumed
    add_row(mkw(MODE_EDGE, 16384, 0, 0, 2560));
    add_row(mkw(MODE_EDGE, 16384, 0, 0, -2560));
    add_row(mkw(MODE_PLANE, 0, 0, 16384, 3200, 3));        // replaced by the next plane
    add_row(mkw(MODE_PLANE, 0, 0, 16384, 3200, 0));
    add_row(mkw(MODE_PLANE, 0, 0, 16384, 3200, 3));
    add_row(mkw(MODE_END, 0, 0, 25600, 0));                // abandons the open facet
    add_row(mkw(MODE_START, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
    add_row(mkw(MODE_PLANE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 0, 1), 1);                  // new ray: best is none

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].w, rows[i].typed, rows[i].r);
    drain();   // sender waits for every result before going on

    cfg_eps = '{0, 255, 0, 0};
    cfg_margin = '{0, 65535, 0, 0};
    for (phase = 0; phase < 4; phase++) begin
      if (phase >= 2) begin
        cfg_eps[phase] = $urandom_range(0, 255);
        cfg_margin[phase] = $urandom_range(0, 1024);
      end
      drain();
      write_reg(REG_EDGE_EPS, 16'(cfg_eps[phase]));
      write_reg(REG_SELF_MARGIN, 16'(cfg_margin[phase]));
      settings_used++;
      new_ray();
      while (words_sent < 30 + (phase + 1) * WORD_TARGET / 4) begin
        if (words_sent % 97 == 0) calm = ($urandom_range(0, 3) == 0);
        p = $urandom_range(0, 99);
        if (p < 12) new_ray();
        else if (p < 80) send_facet($urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                               : $urandom_range(3, 4), -1);
        else if (p < 88) begin
          // broken facet: cut short by a plane, start or end word
          send_facet($urandom_range(3, 4), $urandom_range(0, 2));
          if ($urandom_range(0, 1)) send(mkw(MODE_END, rand_coord(), rand_coord(),
                                             rand_coord(), $urandom));
        end else
          send(mkw(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 7), 1'($urandom_range(0, 1))));
      end
    end
    calm = 1'b0;

    drain();
    if (pending.size() != 0) mismatches++;
    $display("Sent %0d words over %0d register settings; checked %0d results, %0d hits, %0d closer.",
             words_sent, settings_used, words_seen, hits_seen, closer_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
